// ===== src/insertion_sorter_defines.svh =====
// Assertion macros used by the insertion sorter control.
`ifndef INSERTION_SORTER_DEFINES_SVH
`define INSERTION_SORTER_DEFINES_SVH

`ifndef SYNTH
`define ISS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ISS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ISS_ASSERT_SAME(lbl, ante, cons, msg)
`define ISS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== src/iss_pkg.sv =====
// Types and constants shared by the insertion sorter modules.
`timescale 1ns / 1ps
`default_nettype none

package iss_pkg;

    localparam int VALUE_W = 32;

    typedef struct packed {
        logic                      ins;
        logic                      drain;
        logic signed [VALUE_W-1:0] value;
    } t_cell_cmd;

endpackage

`default_nettype wire

// ===== src/iss_cell.sv =====
// One storage cell of the insertion chain.
`timescale 1ns / 1ps
`default_nettype none

module iss_cell (
    input  logic                              i_clk,
    input  iss_pkg::t_cell_cmd                i_cmd,
    input  logic                              i_below,
    input  logic                              i_at_end,
    input  logic                              i_left_greater,
    input  logic signed [iss_pkg::VALUE_W-1:0] i_left_value,
    input  logic signed [iss_pkg::VALUE_W-1:0] i_right_value,
    output logic                              o_greater,
    output logic signed [iss_pkg::VALUE_W-1:0] o_value
);

    logic signed [iss_pkg::VALUE_W-1:0] r_value;
    logic signed [iss_pkg::VALUE_W-1:0] n_value;

    assign o_greater = i_below && (r_value > i_cmd.value);
    assign o_value   = r_value;

    always_comb begin
        n_value = r_value;
        if (i_cmd.ins) begin
            if (i_left_greater) begin
                n_value = i_left_value;
            end else if (o_greater || i_at_end) begin
                n_value = i_cmd.value;
            end
        end else if (i_cmd.drain) begin
            n_value = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

`default_nettype wire

// ===== src/iss_ctrl.sv =====
// Fill and drain control, element count and output register of the sorter.
`timescale 1ns / 1ps
`default_nettype none

`include "insertion_sorter_defines.svh"

module iss_ctrl #(
    parameter int CAPACITY = 64,
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [iss_pkg::VALUE_W-1:0] i_value,
    input  logic                               i_last,
    input  logic signed [iss_pkg::VALUE_W-1:0] i_head_value,
    output iss_pkg::t_cell_cmd                 o_cmd,
    output logic [CW-1:0]                      o_count,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [iss_pkg::VALUE_W-1:0] o_sorted_value,
    output logic                               o_end_of_set,
    output logic                               o_overflow
);

    localparam logic ST_FILL  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic          r_state;
    logic          n_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_dropped;
    logic          n_dropped;
    logic          r_out_valid;
    logic          n_out_valid;
    logic signed [iss_pkg::VALUE_W-1:0] r_out_value;
    logic          r_out_end;
    logic          r_out_ovf;

    logic accept;
    logic full;
    logic load;

    assign o_in_ready = (r_state == ST_FILL);
    assign accept     = i_in_valid && o_in_ready;
    assign full       = (r_count == CW'(CAPACITY));
    assign load       = (r_state == ST_DRAIN) && (!r_out_valid || i_out_ready);

    assign o_cmd.ins   = accept && !full;
    assign o_cmd.drain = load;
    assign o_cmd.value = i_value;
    assign o_count     = r_count;

    assign o_out_valid    = r_out_valid;
    assign o_sorted_value = r_out_value;
    assign o_end_of_set   = r_out_end;
    assign o_overflow     = r_out_ovf;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_dropped   = r_dropped;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            ST_FILL: begin
                if (accept) begin
                    if (full) begin
                        n_dropped = 1'b1;
                    end else begin
                        n_count = r_count + CW'(1);
                    end
                    if (i_last) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (load) begin
                    n_out_valid = 1'b1;
                    n_count     = r_count - CW'(1);
                    if (r_count == CW'(1)) begin
                        n_state   = ST_FILL;
                        n_dropped = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dropped   <= n_dropped;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_value <= i_head_value;
            r_out_end   <= (r_count == CW'(1));
            r_out_ovf   <= r_dropped;
        end
    end

    `ISS_ASSERT_SAME(a_drain_not_empty, r_state == ST_DRAIN, r_count != '0, "Draining an empty chain")
    `ISS_ASSERT_SAME(a_count_bound, 1'b1, r_count <= CW'(CAPACITY), "Element count above capacity")
    `ISS_ASSERT_NEXT(a_last_drains, accept && i_last, r_state == ST_DRAIN, "Last item did not start drain")
    `ISS_ASSERT_NEXT(a_end_clears, load && r_count == CW'(1), r_state == ST_FILL && !r_dropped && r_out_end, "Set end did not clear state")

endmodule

`default_nettype wire

// ===== src/insertion_sorter.sv =====
// Top level of the insertion sorter: a chain of sorting cells and its control.
`timescale 1ns / 1ps
`default_nettype none

// A set of signed values enters one item per cycle; each value is placed into an
// ascending chain of CAPACITY cells in the cycle it is accepted, larger values moving
// up one cell. After the item marked last, the chain shifts toward its head and the set
// leaves in ascending order, one result per cycle while the output is taken, the final
// result flagged end_of_set. Input is held off while the chain drains, and the next set
// may start while the final result still waits in the output register. Values arriving
// when all cells are occupied are dropped, and every result of that set then carries
// overflow.

module insertion_sorter #(
    parameter int CAPACITY = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [iss_pkg::VALUE_W-1:0] i_value,
    input  logic                               i_last,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [iss_pkg::VALUE_W-1:0] o_sorted_value,
    output logic                               o_end_of_set,
    output logic                               o_overflow
);

    localparam int CW = $clog2(CAPACITY + 1);

    iss_pkg::t_cell_cmd w_cmd;
    logic [CW-1:0]      w_count;
    logic                               w_greater [CAPACITY];
    logic signed [iss_pkg::VALUE_W-1:0] w_value   [CAPACITY];

    iss_ctrl #(
        .CAPACITY (CAPACITY),
        .CW       (CW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_value        (i_value),
        .i_last         (i_last),
        .i_head_value   (w_value[0]),
        .o_cmd          (w_cmd),
        .o_count        (w_count),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_sorted_value (o_sorted_value),
        .o_end_of_set   (o_end_of_set),
        .o_overflow     (o_overflow)
    );

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                               w_left_greater;
        logic signed [iss_pkg::VALUE_W-1:0] w_left_value;
        logic signed [iss_pkg::VALUE_W-1:0] w_right_value;

        if (g == 0) begin : g_head
            assign w_left_greater = 1'b0;
            assign w_left_value   = w_value[g];
        end else begin : g_body
            assign w_left_greater = w_greater[g-1];
            assign w_left_value   = w_value[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right_value = w_value[g];
        end else begin : g_mid
            assign w_right_value = w_value[g+1];
        end

        iss_cell u_cell (
            .i_clk          (i_clk),
            .i_cmd          (w_cmd),
            .i_below        (w_count > CW'(g)),
            .i_at_end       (w_count == CW'(g)),
            .i_left_greater (w_left_greater),
            .i_left_value   (w_left_value),
            .i_right_value  (w_right_value),
            .o_greater      (w_greater[g]),
            .o_value        (w_value[g])
        );
    end

endmodule

`default_nettype wire
